// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// a implies b in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

// condition never holds
`define ASSERT_NEVER(label, clk, rst, a, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(a)) else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, a, b, msg)
`define ASSERT_NEXT(label, clk, rst, a, b, msg)
`define ASSERT_NEVER(label, clk, rst, a, msg)

`endif

`endif

// ===== rtl/aenc_pkg.sv =====
// ---------------------------------------------------------------------------
// aenc_pkg
// Types, codes and token tables for the Accept-Encoding selector.
// ---------------------------------------------------------------------------
package aenc_pkg;

   // byte classes from the front end
   localparam logic [1:0] KIND_TEXT  = 2'd0;
   localparam logic [1:0] KIND_COMMA = 2'd1;
   localparam logic [1:0] KIND_SEMI  = 2'd2;
   localparam logic [1:0] KIND_SPACE = 2'd3;

   // result codes
   localparam logic [1:0] ENC_IDENTITY = 2'd0;
   localparam logic [1:0] ENC_GZIP     = 2'd1;
   localparam logic [1:0] ENC_DEFLATE  = 2'd2;

   // candidate / allowed bit positions
   localparam int CAND_GZIP    = 0;
   localparam int CAND_DEFLATE = 1;
   localparam int CAND_STAR    = 2;

   // quality search phases
   localparam logic [1:0] PHASE_SEEK  = 2'd0;
   localparam logic [1:0] PHASE_Q     = 2'd1;
   localparam logic [1:0] PHASE_VALUE = 2'd2;

   // value start kinds
   localparam logic [1:0] VSK_EMPTY = 2'd0;
   localparam logic [1:0] VSK_ZERO  = 2'd1;
   localparam logic [1:0] VSK_OTHER = 2'd2;

   localparam logic [3:0] GZIP_LEN      = 4'd4;
   localparam logic [3:0] DEFLATE_LEN   = 4'd7;
   localparam logic [3:0] STAR_LEN      = 4'd1;
   localparam logic [3:0] TOKEN_LEN_MAX = 4'd8;

   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_EQ    = 8'h3D;
   localparam logic [7:0] CHAR_Q     = 8'h71;

   localparam int AENC_QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] lower;      // A-Z folded to lower case
      logic       is_q;       // case-sensitive 'q'
      logic       is_eq;
      logic       is_zero;
      logic       is_nz_digit;
      logic       last;
   } aenc_item_type;

   function automatic logic [7:0] gzip_char(input logic [1:0] pos);
      logic [7:0] c;
      case (pos)
         2'd0:    c = 8'h67;
         2'd1:    c = 8'h7A;
         2'd2:    c = 8'h69;
         default: c = 8'h70;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] deflate_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h64;
         3'd1:    c = 8'h65;
         3'd2:    c = 8'h66;
         3'd3:    c = 8'h6C;
         3'd4:    c = 8'h61;
         3'd5:    c = 8'h74;
         3'd6:    c = 8'h65;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/aenc_front.sv =====
// ---------------------------------------------------------------------------
// aenc_front
// Accepts header bytes and classifies them for the back end.
// ---------------------------------------------------------------------------
module aenc_front
   import aenc_pkg::*;
(
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // [7:0] header_byte
   input  logic          req_tlast,   // last_byte
   input  logic          q_ready,
   output logic          q_push,
   output aenc_item_type q_item
);

   logic is_upper;
   logic is_space;

   assign req_tready = q_ready;
   assign q_push     = req_tvalid & q_ready;

   assign is_upper = (req_tdata >= 8'h41) && (req_tdata <= 8'h5A);
   assign is_space = (req_tdata == 8'h20) || ((req_tdata >= 8'h09) && (req_tdata <= 8'h0D));

   always_comb begin
      q_item.lower       = is_upper ? (req_tdata | 8'h20) : req_tdata;
      q_item.is_q        = (req_tdata == CHAR_Q);
      q_item.is_eq       = (req_tdata == CHAR_EQ);
      q_item.is_zero     = (req_tdata == CHAR_ZERO);
      q_item.is_nz_digit = (req_tdata >= CHAR_ONE) && (req_tdata <= CHAR_NINE);
      q_item.last        = req_tlast;
      if (req_tdata == CHAR_COMMA) begin
         q_item.kind = KIND_COMMA;
      end else if (req_tdata == CHAR_SEMI) begin
         q_item.kind = KIND_SEMI;
      end else if (is_space) begin
         q_item.kind = KIND_SPACE;
      end else begin
         q_item.kind = KIND_TEXT;
      end
   end

endmodule

// ===== rtl/aenc_queue.sv =====
// ---------------------------------------------------------------------------
// aenc_queue
// Small FIFO of classified bytes between front and back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module aenc_queue
   import aenc_pkg::*;
#(
   parameter int DEPTH = AENC_QUEUE_DEPTH
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  aenc_item_type push_item,
   output logic          ready,
   input  logic          pop,
   output logic          valid,
   output aenc_item_type pop_item
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   aenc_item_type   store_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign ready    = (count_ff != FULL_CNT);
   assign valid    = (count_ff != '0);
   assign pop_item = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

   `ASSERT_NEVER(a_q_overflow, clock, reset, push && !ready, "queue push while full")
   `ASSERT_NEVER(a_q_underflow, clock, reset, pop && !valid, "queue pop while empty")
   `ASSERT_IMPLIES(a_q_ptrs, clock, reset, count_ff == '0, wr_ptr_ff == rd_ptr_ff, "pointer mismatch when empty")

endmodule

// ===== rtl/aenc_back.sv =====
// ---------------------------------------------------------------------------
// aenc_back
// Per-entry parse state, allowed flags and the registered result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module aenc_back
   import aenc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  aenc_item_type q_item,
   output logic          q_pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata    // [1:0] selected_encoding, [7:2] zero
);

   logic       param_ff, param_in, upd_param;
   logic [2:0] cand_ff, cand_in, upd_cand;
   logic [3:0] len_ff, len_in, upd_len;
   logic [1:0] phase_ff, phase_in, upd_phase;
   logic [1:0] vsk_ff, vsk_in, upd_vsk;
   logic       nz_ff, nz_in, upd_nz;
   logic [2:0] allowed_ff, allowed_in, allowed_next;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_enc_ff, rsp_enc_in;

   logic       is_comma, closing, rejected;
   logic [2:0] cl_cand, hits, tok_match;
   logic [3:0] cl_len;
   logic [1:0] cl_vsk;
   logic       cl_nz;
   logic [1:0] sel;

   // a last byte may only go once the result register is free
   assign q_pop      = q_valid && (!q_item.last || !rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_enc_ff};
   assign is_comma   = (q_item.kind == KIND_COMMA);
   assign closing    = is_comma || q_item.last;

   always_comb begin
      tok_match[CAND_GZIP]    = (len_ff < GZIP_LEN) && (q_item.lower == gzip_char(len_ff[1:0]));
      tok_match[CAND_DEFLATE] = (len_ff < DEFLATE_LEN)
                                && (q_item.lower == deflate_char(len_ff[2:0]));
      tok_match[CAND_STAR]    = (len_ff == '0) && (q_item.lower == CHAR_STAR);
   end

   // entry state after this byte
   always_comb begin
      upd_param = param_ff;
      upd_cand  = cand_ff;
      upd_len   = len_ff;
      upd_phase = phase_ff;
      upd_vsk   = vsk_ff;
      upd_nz    = nz_ff;
      if (is_comma) begin
         upd_param = param_ff;
      end else if (param_ff) begin
         case (phase_ff)
            PHASE_VALUE: begin
               if (vsk_ff == VSK_EMPTY) begin
                  upd_vsk = q_item.is_zero ? VSK_ZERO : VSK_OTHER;
               end
               upd_nz = nz_ff | q_item.is_nz_digit;
            end
            PHASE_Q: begin
               if (q_item.is_eq) begin
                  upd_phase = PHASE_VALUE;
               end else if (!q_item.is_q) begin
                  upd_phase = PHASE_SEEK;
               end
            end
            default: begin
               if (q_item.is_q) begin
                  upd_phase = PHASE_Q;
               end
            end
         endcase
      end else begin
         case (q_item.kind)
            KIND_SEMI:  upd_param = 1'b1;
            KIND_SPACE: upd_param = param_ff;
            default: begin
               upd_cand = cand_ff & tok_match;
               if (len_ff < TOKEN_LEN_MAX) begin
                  upd_len = len_ff + 1'b1;
               end
            end
         endcase
      end
   end

   // entry closing: a comma closes the entry as it stood before the comma
   always_comb begin
      cl_cand  = is_comma ? cand_ff : upd_cand;
      cl_len   = is_comma ? len_ff  : upd_len;
      cl_vsk   = is_comma ? vsk_ff  : upd_vsk;
      cl_nz    = is_comma ? nz_ff   : upd_nz;
      rejected = (cl_vsk == VSK_ZERO) && !cl_nz;
      hits[CAND_GZIP]    = cl_cand[CAND_GZIP]    && (cl_len == GZIP_LEN);
      hits[CAND_DEFLATE] = cl_cand[CAND_DEFLATE] && (cl_len == DEFLATE_LEN);
      hits[CAND_STAR]    = cl_cand[CAND_STAR]    && (cl_len == STAR_LEN);
      allowed_next = (closing && !rejected) ? (allowed_ff | hits) : allowed_ff;
      if (allowed_next[CAND_GZIP]) begin
         sel = ENC_GZIP;
      end else if (allowed_next[CAND_DEFLATE]) begin
         sel = ENC_DEFLATE;
      end else if (allowed_next[CAND_STAR]) begin
         sel = ENC_GZIP;
      end else begin
         sel = ENC_IDENTITY;
      end
   end

   always_comb begin
      param_in     = param_ff;
      cand_in      = cand_ff;
      len_in       = len_ff;
      phase_in     = phase_ff;
      vsk_in       = vsk_ff;
      nz_in        = nz_ff;
      allowed_in   = allowed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_enc_in   = rsp_enc_ff;
      if (q_pop) begin
         if (closing) begin
            param_in = 1'b0;
            cand_in  = 3'b111;
            len_in   = '0;
            phase_in = PHASE_SEEK;
            vsk_in   = VSK_EMPTY;
            nz_in    = 1'b0;
         end else begin
            param_in = upd_param;
            cand_in  = upd_cand;
            len_in   = upd_len;
            phase_in = upd_phase;
            vsk_in   = upd_vsk;
            nz_in    = upd_nz;
         end
         if (q_item.last) begin
            allowed_in   = '0;
            rsp_valid_in = 1'b1;
            rsp_enc_in   = sel;
         end else begin
            allowed_in = allowed_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         param_ff     <= 1'b0;
         cand_ff      <= 3'b111;
         len_ff       <= '0;
         phase_ff     <= PHASE_SEEK;
         vsk_ff       <= VSK_EMPTY;
         nz_ff        <= 1'b0;
         allowed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         param_ff     <= param_in;
         cand_ff      <= cand_in;
         len_ff       <= len_in;
         phase_ff     <= phase_in;
         vsk_ff       <= vsk_in;
         nz_ff        <= nz_in;
         allowed_ff   <= allowed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_enc_ff <= rsp_enc_in;
   end

   `ASSERT_NEXT(a_last_clears, clock, reset, q_pop && q_item.last, allowed_ff == '0 && len_ff == '0, "state not cleared after last byte")
   `ASSERT_NEVER(a_no_overwrite, clock, reset, q_pop && q_item.last && rsp_valid_ff && !rsp_tready, "result overwritten while stalled")
   `ASSERT_NEVER(a_enc_range, clock, reset, rsp_valid_ff && rsp_enc_ff == 2'd3, "invalid encoding code")
   `ASSERT_NEVER(a_len_sat, clock, reset, len_ff > TOKEN_LEN_MAX, "token length past saturation")

endmodule

// ===== rtl/accept_encoding_selector_top.sv =====
// ---------------------------------------------------------------------------
// accept_encoding_selector_top
// Picks a content coding from a streamed Accept-Encoding header value.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one header character per transfer, req_tlast on the final
//   character. rsp_* carries one result per header: rsp_tdata[1:0] is
//   0 identity, 1 gzip, 2 deflate.
//   Throughput: one character per cycle, unless a last character is held
//   back by a pending result (see Stall). The front end classifies each
//   character into a small queue; the back end consumes one queue entry
//   per cycle under the same condition.
//   Result path: the last character is written into the queue, and the
//   result register loads as that character leaves the queue.
//   Stall: the result register holds until rsp_tready. While it waits the
//   back end keeps consuming characters of the next header; only a second
//   last character waits, and the queue fills before req_tready drops.
//   Reset: synchronous, active high; clears the queue, the parse state, the
//   allowed flags and the pending result.
// ---------------------------------------------------------------------------
module accept_encoding_selector_top
   import aenc_pkg::*;
#(
   parameter int QUEUE_DEPTH = AENC_QUEUE_DEPTH
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] header_byte
   input  logic       req_tlast,    // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata     // [1:0] selected_encoding, [7:2] zero
);

   logic          q_push, q_ready, q_pop, q_valid;
   aenc_item_type push_item, pop_item;

   aenc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   aenc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .ready     (q_ready),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_item  (pop_item)
   );

   aenc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (pop_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== tb/tb_accept_encoding_selector_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_accept_encoding_selector_top
// Streams Accept-Encoding header values into the selector one character per
// transfer. A model of the entry parser, running in step with the accepted
// characters, queues the encoding that each header should select. Every
// result transfer is checked against the head of that queue. A directed table
// covers the named corner cases. Random headers follow: mostly well-formed
// entry lists, with some broken and some noise headers, under three
// back-pressure mixes.
// ---------------------------------------------------------------------------
module tb_accept_encoding_selector_top;
   import aenc_pkg::*;

   typedef struct {
      string      text;
      bit         has_tail;
      logic [7:0] tail;
      bit         pinned;
      logic [1:0] code;
   } header_case_type;

   localparam logic [31:0] GZIP_WORD    = "gzip";
   localparam logic [55:0] DEFLATE_WORD = "deflate";

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;

   accept_encoding_selector_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] header_byte
      .req_tlast  (req_tlast),    // last_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)     // [1:0] selected_encoding, [7:2] zero
   );

   always #5 clock = ~clock;

   // parser model state
   logic       in_params = 1'b0;
   logic [2:0] cands     = 3'b111;
   logic [3:0] tok_len   = 4'd0;
   logic [1:0] q_phase   = PHASE_SEEK;
   logic [1:0] val_kind  = VSK_EMPTY;
   logic       nz_seen   = 1'b0;
   logic [2:0] allowed   = 3'b000;

   logic [1:0]      expected_codes[$];
   logic [7:0]      hdr_bytes[$];
   header_case_type header_cases[$];
   bit              pin_valid = 1'b0;
   logic [1:0]      pin_code  = ENC_IDENTITY;

   int req_idle_pct = 13;
   int rsp_idle_pct = 66;
   int errors       = 0;
   int bytes_sent   = 0;
   int headers_sent = 0;
   int results_seen = 0;
   int code_count[4];
   logic [7:0] want_word;

   string token_words[13] = '{"gzip", "gzip", "deflate", "deflate", "*", "identity",
                              "br", "gzi", "deflat", "gzipx", "deflatee", "x-gzip", "**"};
   string q_values[12] = '{"0", "0.0", "0.000", "1", "0.5", "1.000", "", "0.001",
                           "00", "0;1", "0;", "a0"};
   string broken_text[6] = '{"gzip;q", "deflat", ";q=0", "gz ip;q=0.", "q=0,gzip;", ";;,;"};
   logic [7:0] blank_chars[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

   task automatic close_entry();
      if (!(val_kind == VSK_ZERO && !nz_seen)) begin
         if (cands[CAND_GZIP] && tok_len == GZIP_LEN) allowed[CAND_GZIP] = 1'b1;
         if (cands[CAND_DEFLATE] && tok_len == DEFLATE_LEN) allowed[CAND_DEFLATE] = 1'b1;
         if (cands[CAND_STAR] && tok_len == STAR_LEN) allowed[CAND_STAR] = 1'b1;
      end
      in_params = 1'b0;
      cands     = 3'b111;
      tok_len   = 4'd0;
      q_phase   = PHASE_SEEK;
      val_kind  = VSK_EMPTY;
      nz_seen   = 1'b0;
   endtask

   // advance the parser model by one accepted character
   task automatic track_encoding(input logic [7:0] ch, input logic is_last);
      logic [7:0] low;
      logic [1:0] pick;
      int         pos;
      pos = tok_len;
      low = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
      if (ch == CHAR_COMMA) begin
         close_entry();
      end else if (in_params) begin
         if (q_phase == PHASE_VALUE) begin
            if (val_kind == VSK_EMPTY) val_kind = (ch == CHAR_ZERO) ? VSK_ZERO : VSK_OTHER;
            if (ch >= CHAR_ONE && ch <= CHAR_NINE) nz_seen = 1'b1;
         end else if (q_phase == PHASE_Q) begin
            if (ch == CHAR_EQ) q_phase = PHASE_VALUE;
            else if (ch != CHAR_Q) q_phase = PHASE_SEEK;
         end else if (ch == CHAR_Q) begin
            q_phase = PHASE_Q;
         end
      end else if (ch == CHAR_SEMI) begin
         in_params = 1'b1;
      end else if (!(ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D))) begin
         if (pos >= 4) cands[CAND_GZIP] = 1'b0;
         else if (low != GZIP_WORD[8*(3-pos) +: 8]) cands[CAND_GZIP] = 1'b0;
         if (pos >= 7) cands[CAND_DEFLATE] = 1'b0;
         else if (low != DEFLATE_WORD[8*(6-pos) +: 8]) cands[CAND_DEFLATE] = 1'b0;
         if (pos >= 1 || low != CHAR_STAR) cands[CAND_STAR] = 1'b0;
         if (tok_len < TOKEN_LEN_MAX) tok_len = tok_len + 4'd1;
      end
      if (is_last) begin
         close_entry();
         if (allowed[CAND_GZIP]) pick = ENC_GZIP;
         else if (allowed[CAND_DEFLATE]) pick = ENC_DEFLATE;
         else if (allowed[CAND_STAR]) pick = ENC_GZIP;
         else pick = ENC_IDENTITY;
         expected_codes.insert(expected_codes.size(), pin_valid ? pin_code : pick);
         allowed = 3'b000;
         headers_sent++;
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic l);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_encoding(b, l);
      bytes_sent++;
   endtask

   task automatic send_header();
      for (int i = 0; i < hdr_bytes.size(); i++)
         send_byte(hdr_bytes[i], i == hdr_bytes.size() - 1);
   endtask

   task automatic append_byte(input logic [7:0] b);
      hdr_bytes.insert(hdr_bytes.size(), b);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) append_byte(s[i]);
   endtask

   task automatic add_case(input string text, input bit has_tail, input logic [7:0] tail,
                           input bit pinned, input logic [1:0] code);
      header_case_type hc;
      hc.text     = text;
      hc.has_tail = has_tail;
      hc.tail     = tail;
      hc.pinned   = pinned;
      hc.code     = code;
      header_cases.insert(header_cases.size(), hc);
   endtask

   task automatic build_random_header();
      int         kind;
      int         n_entries;
      int         pick;
      string      tok;
      logic [7:0] c;
      hdr_bytes.delete();
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         // noise: any byte value at all
         n_entries = $urandom_range(1, 10);
         repeat (n_entries) append_byte(8'($urandom_range(0, 255)));
      end else if (kind < 20) begin
         push_text(broken_text[$urandom_range(0, 5)]);
      end else begin
         n_entries = $urandom_range(1, 4);
         for (int e = 0; e < n_entries; e++) begin
            if (e > 0) begin
               append_byte(CHAR_COMMA);
               if ($urandom_range(0, 1)) append_byte(8'h20);
            end
            tok = token_words[$urandom_range(0, 12)];
            for (int i = 0; i < tok.len(); i++) begin
               if ($urandom_range(0, 99) < 15) append_byte(blank_chars[$urandom_range(0, 5)]);
               c = tok[i];
               if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
               append_byte(c);
            end
            if ($urandom_range(0, 9) == 0) append_byte(8'($urandom_range(128, 255)));
            if ($urandom_range(0, 1)) begin
               append_byte(CHAR_SEMI);
               if ($urandom_range(0, 4) == 0) push_text("level=9;");
               pick = $urandom_range(0, 9);
               if (pick == 0) push_text("Q=");
               else if (pick == 1) push_text("qq=");
               else push_text("q=");
               push_text(q_values[$urandom_range(0, 11)]);
            end
         end
         if ($urandom_range(0, 9) == 0) append_byte(CHAR_COMMA);
      end
   endtask

   // result checker and receiver back-pressure
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         code_count[rsp_tdata[1:0]]++;
         if (expected_codes.size() == 0) begin
            $display("%0t: result with nothing expected, expected none actual %h",
                     $time, rsp_tdata);
            errors++;
         end else begin
            want_word = {6'b000000, expected_codes.pop_front()};
            if (rsp_tdata !== want_word) begin
               $display("%0t: selected_encoding mismatch, expected %h actual %h",
                        $time, want_word, rsp_tdata);
               errors++;
            end
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int start_bytes;
      int start_hdrs;

      add_case("gzip",     0, 8'h00, 1, ENC_GZIP);
      add_case("deflate",  0, 8'h00, 1, ENC_DEFLATE);
      add_case("*",        0, 8'h00, 1, ENC_GZIP);
      add_case("identity", 0, 8'h00, 1, ENC_IDENTITY);
      add_case("",         1, 8'hFF, 1, ENC_IDENTITY);
      add_case("",         1, 8'h00, 1, ENC_IDENTITY);
      add_case("GZIP",     0, 8'h00, 1, ENC_GZIP);
      add_case(" De\tfl\nate\r", 0, 8'h00, 0, ENC_IDENTITY);
      add_case("deflate;q=0",     0, 8'h00, 1, ENC_IDENTITY);
      add_case("deflate;q=0.000", 0, 8'h00, 1, ENC_IDENTITY);
      add_case("deflate;q=0.001", 0, 8'h00, 0, ENC_IDENTITY);
      add_case("deflate;q=",      0, 8'h00, 0, ENC_IDENTITY);
      add_case("deflate;Q=0",     0, 8'h00, 0, ENC_IDENTITY);
      add_case("deflate;level=0;q=0;5", 0, 8'h00, 0, ENC_IDENTITY);
      add_case("deflate;qq=0",    0, 8'h00, 0, ENC_IDENTITY);
      add_case("deflate, gzip",   0, 8'h00, 1, ENC_GZIP);
      add_case("gzip;q=0, deflate", 0, 8'h00, 0, ENC_IDENTITY);
      add_case("*;q=0.5,identity",  0, 8'h00, 0, ENC_IDENTITY);
      add_case("gzip,",      0, 8'h00, 0, ENC_IDENTITY);
      add_case("gzipgzip",   0, 8'h00, 0, ENC_IDENTITY);
      add_case("deflate",    1, 8'h80, 0, ENC_IDENTITY);
      add_case(",,,",        0, 8'h00, 0, ENC_IDENTITY);
      add_case("*;q=0, deflate;q=0", 0, 8'h00, 1, ENC_IDENTITY);
      add_case("\v\f",       0, 8'h00, 1, ENC_IDENTITY);
      add_case("defla",      0, 8'h00, 0, ENC_IDENTITY);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (header_cases[i]) begin
         hdr_bytes.delete();
         push_text(header_cases[i].text);
         if (header_cases[i].has_tail) append_byte(header_cases[i].tail);
         pin_valid = header_cases[i].pinned;
         pin_code  = header_cases[i].code;
         send_header();
         pin_valid = 1'b0;
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 13;
               rsp_idle_pct = 66;
            end
            1: begin
               req_idle_pct = 66;
               rsp_idle_pct = 13;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         start_bytes = bytes_sent;
         start_hdrs  = headers_sent;
         while (bytes_sent - start_bytes < 90 || headers_sent - start_hdrs < 5) begin
            build_random_header();
            send_header();
         end
      end

      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d headers in %0d character transfers under three stall mixes",
               headers_sent, bytes_sent);
      $display("Checked %0d results: %0d identity, %0d gzip, %0d deflate",
               results_seen, code_count[ENC_IDENTITY], code_count[ENC_GZIP],
               code_count[ENC_DEFLATE]);
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== accept_encoding_selector_top.f =====
+incdir+rtl
rtl/aenc_pkg.sv
rtl/aenc_front.sv
rtl/aenc_queue.sv
rtl/aenc_back.sv
rtl/accept_encoding_selector_top.sv
tb/tb_accept_encoding_selector_top.sv
